### sv/rpa_pkg.sv
// Shared types, codes and constants for the reference-counted page allocator.
// Used by every module of the block; the channel interfaces stand alone.
package rpa_pkg;

    localparam int MAX_PAGES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int COUNT_BITS_DEF = 8;

    localparam int BASE_W        = 20;
    localparam int NUM_W         = 16;
    localparam int APB_AW        = 3;
    localparam int NUM_PAGES_RST = 32768;

    localparam logic REG_BASE_PAGE = 1'b0;
    localparam logic REG_NUM_PAGES = 1'b1;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INCR  = 2'd2,
        ACT_DECR  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        RS_OK         = 3'd0,
        RS_NONE_FREE  = 3'd1,
        RS_BAD_ADDR   = 3'd2,
        RS_UNDERFLOW  = 3'd3,
        RS_OVERFLOW   = 3'd4,
        RS_STACK_FULL = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic pop_stack;
        logic pop_fresh;
        logic push;
    } t_src_cmd;

    typedef struct packed {
        logic stack_empty;
        logic stack_full;
        logic fresh_empty;
    } t_src_stat;

    // Number of pages actually managed: the programmed count, capped at capacity.
    function automatic logic [NUM_W-1:0] clip_pages(input logic [NUM_W-1:0] num,
                                                    input int max_pages);
        logic [NUM_W-1:0] res;
        res = num;
        if (int'(num) > max_pages) begin
            res = NUM_W'(max_pages);
        end
        return res;
    endfunction

endpackage

### sv/rpa_if.sv
// Valid/ready channel interfaces for the page allocator requests and responses.
// Stand-alone; the payload fields are plain vectors.
interface rpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] page_addr;

    modport source (output valid, action, page_addr, input ready);
    modport sink   (input valid, action, page_addr, output ready);
endinterface

interface rpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] alloc_addr;
    logic        reached_zero;
    logic [7:0]  new_count;

    modport source (output valid, status, alloc_addr, reached_zero, new_count, input ready);
    modport sink   (input valid, status, alloc_addr, reached_zero, new_count, output ready);
endinterface

### sv/rpa_cfg_regs.sv
// APB configuration registers: base page and number of managed pages.
// Depends on rpa_pkg for register indexes and the page-count clip function.
module rpa_cfg_regs import rpa_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [BASE_W-1:0] o_base_page,
    output logic [NUM_W-1:0]  o_pages_in_use,
    output logic              o_reload,
    output logic [NUM_W-1:0]  o_reload_pages
);

    logic [BASE_W-1:0] r_base_page;
    logic [NUM_W-1:0]  r_num_pages;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_page <= '0;
            r_num_pages <= NUM_W'(NUM_PAGES_RST);
        end else if (wr_en) begin
            case (paddr[2])
                REG_BASE_PAGE: r_base_page <= pwdata[BASE_W-1:0];
                REG_NUM_PAGES: r_num_pages <= pwdata[NUM_W-1:0];
                default:       r_base_page <= r_base_page;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BASE_PAGE: prdata = 32'(r_base_page);
            REG_NUM_PAGES: prdata = 32'(r_num_pages);
            default:       prdata = '0;
        endcase
    end

    assign o_base_page    = r_base_page;
    assign o_pages_in_use = clip_pages(r_num_pages, MAX_PAGES);
    assign o_reload       = wr_en && (paddr[2] == REG_NUM_PAGES);
    assign o_reload_pages = clip_pages(pwdata[NUM_W-1:0], MAX_PAGES);

endmodule

### sv/rpa_ref_counts.sv
// Reference count memory with a clearing sweep after reset.
// Depends on rpa_pkg for default parameter values.
module rpa_ref_counts import rpa_pkg::*; #(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_PAGES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_idx,
    output logic [COUNT_BITS-1:0] o_rd_data,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  logic [COUNT_BITS-1:0] i_wr_data,
    output logic                  o_busy
);

    logic [COUNT_BITS-1:0] r_cnt [0:MAX_PAGES-1];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]      r_clr_idx;
    logic                  r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(MAX_PAGES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_cnt[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_cnt[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_cnt[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

### sv/rpa_page_source.sv
// Free page source: LIFO memory of returned pages, its depth, and the fresh page counter.
// Depends on rpa_pkg for the command and status structs.
module rpa_page_source import rpa_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    localparam int IDX_W    = $clog2(MAX_PAGES),
    localparam int DEPTH_W  = $clog2(MAX_PAGES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_src_cmd         i_cmd,
    input  logic [IDX_W-1:0] i_push_idx,
    input  logic             i_reload,
    input  logic [NUM_W-1:0] i_reload_pages,
    output t_src_stat        o_stat,
    output logic [IDX_W-1:0] o_top_idx,
    output logic [IDX_W-1:0] o_fresh_idx
);

    localparam logic [NUM_W-1:0] FRESH_RST = clip_pages(NUM_W'(NUM_PAGES_RST), MAX_PAGES);

    logic [IDX_W-1:0]   r_stack [0:MAX_PAGES-1];
    logic [IDX_W-1:0]   r_top;
    logic [DEPTH_W-1:0] r_depth;
    logic [NUM_W-1:0]   r_fresh;
    logic [DEPTH_W-1:0] depth_m1;

    assign depth_m1 = r_depth - DEPTH_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_depth[IDX_W-1:0]] <= i_push_idx;
        end
        r_top <= r_stack[depth_m1[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fresh <= FRESH_RST;
        end else begin
            if (i_cmd.push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (i_cmd.pop_stack) begin
                r_depth <= depth_m1;
            end
            if (i_reload) begin
                r_fresh <= i_reload_pages;
            end else if (i_cmd.pop_fresh) begin
                r_fresh <= r_fresh - NUM_W'(1);
            end
        end
    end

    assign o_stat.stack_empty = (r_depth == '0);
    assign o_stat.stack_full  = (r_depth >= DEPTH_W'(MAX_PAGES));
    assign o_stat.fresh_empty = (r_fresh == '0);
    assign o_top_idx          = r_top;
    assign o_fresh_idx        = IDX_W'(r_fresh - NUM_W'(1));

endmodule

### sv/rpa_core.sv
// Request sequencer: address check, count read-modify-write, page source control
// and the response register. Depends on rpa_pkg and the channel interfaces.
module rpa_core import rpa_pkg::*; #(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_PAGES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rpa_req_if.sink               i_req,
    rpa_rsp_if.source             o_rsp,
    input  logic [BASE_W-1:0]     i_base_page,
    input  logic [NUM_W-1:0]      i_pages_in_use,
    input  logic                  i_cnt_busy,
    output logic                  o_cnt_rd_en,
    output logic [IDX_W-1:0]      o_cnt_rd_idx,
    input  logic [COUNT_BITS-1:0] i_cnt_rd_data,
    output logic                  o_cnt_wr_en,
    output logic [IDX_W-1:0]      o_cnt_wr_idx,
    output logic [COUNT_BITS-1:0] o_cnt_wr_data,
    output t_src_cmd              o_src_cmd,
    output logic [IDX_W-1:0]      o_push_idx,
    input  t_src_stat             i_src_stat,
    input  logic [IDX_W-1:0]      i_top_idx,
    input  logic [IDX_W-1:0]      i_fresh_idx
);

    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int PN_W  = 32 - PG_SH;
    localparam int DW    = ((PN_W > BASE_W) ? PN_W : BASE_W) + 1;
    localparam int SUM_W = BASE_W + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_state  r_state, n_state;
    t_action r_action;
    logic [IDX_W-1:0] r_idx;
    logic             r_addr_ok;

    logic             r_out_valid;
    t_status          r_status;
    logic [31:0]      r_alloc_addr;
    logic             r_zero;
    logic [7:0]       r_new_count;

    logic             accept;
    logic [DW-1:0]    diff;
    logic             addr_ok_d;

    logic             fire;
    t_status          res_status;
    logic [31:0]      res_alloc;
    logic             res_zero;
    logic [COUNT_BITS-1:0] res_count;
    logic [15:0]      count_wide;
    logic             wr_raw;
    logic [IDX_W-1:0] alloc_idx;
    logic [SUM_W-1:0] page_sum;
    t_src_cmd         cmd_raw;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign diff      = DW'(i_req.page_addr[31:PG_SH]) - DW'(i_base_page);
    assign addr_ok_d = (i_req.page_addr[PG_SH-1:0] == '0) && !diff[DW-1]
                       && (diff[DW-2:0] < (DW-1)'(i_pages_in_use));

    assign o_cnt_rd_en  = accept;
    assign o_cnt_rd_idx = IDX_W'(diff);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= t_action'(i_req.action);
            r_idx     <= IDX_W'(diff);
            r_addr_ok <= addr_ok_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign fire = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (!i_cnt_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        res_status = RS_OK;
        res_alloc  = '0;
        res_zero   = 1'b0;
        res_count  = '0;
        wr_raw     = 1'b0;
        cmd_raw    = '0;
        alloc_idx  = i_top_idx;
        o_cnt_wr_idx  = r_idx;
        o_cnt_wr_data = '0;
        page_sum   = '0;
        case (r_action)
            ACT_ALLOC: begin
                if (!i_src_stat.stack_empty) begin
                    cmd_raw.pop_stack = 1'b1;
                end else if (!i_src_stat.fresh_empty) begin
                    alloc_idx         = i_fresh_idx;
                    cmd_raw.pop_fresh = 1'b1;
                end else begin
                    res_status = RS_NONE_FREE;
                end
                if (res_status == RS_OK) begin
                    page_sum      = SUM_W'(i_base_page) + SUM_W'(alloc_idx);
                    res_alloc     = 32'(page_sum) << PG_SH;
                    res_count     = COUNT_BITS'(1);
                    wr_raw        = 1'b1;
                    o_cnt_wr_idx  = alloc_idx;
                    o_cnt_wr_data = COUNT_BITS'(1);
                end
            end
            default: begin
                if (!r_addr_ok) begin
                    res_status = RS_BAD_ADDR;
                end else if (r_action == ACT_INCR) begin
                    res_count = i_cnt_rd_data;
                    if (i_cnt_rd_data == CNT_MAX) begin
                        res_status = RS_OVERFLOW;
                    end else begin
                        res_count     = i_cnt_rd_data + COUNT_BITS'(1);
                        wr_raw        = 1'b1;
                        o_cnt_wr_data = res_count;
                    end
                end else if (i_cnt_rd_data == '0) begin
                    res_status = RS_UNDERFLOW;
                end else if (r_action == ACT_FREE && i_cnt_rd_data == COUNT_BITS'(1)
                             && i_src_stat.stack_full) begin
                    res_status = RS_STACK_FULL;
                    res_count  = i_cnt_rd_data;
                end else begin
                    res_count     = i_cnt_rd_data - COUNT_BITS'(1);
                    wr_raw        = 1'b1;
                    o_cnt_wr_data = res_count;
                    if (res_count == '0) begin
                        res_zero     = 1'b1;
                        cmd_raw.push = (r_action == ACT_FREE);
                    end
                end
            end
        endcase
    end

    assign o_cnt_wr_en = fire && wr_raw;
    assign o_src_cmd   = fire ? cmd_raw : '0;
    assign o_push_idx  = r_idx;
    assign count_wide  = 16'(res_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status     <= res_status;
            r_alloc_addr <= res_alloc;
            r_zero       <= res_zero;
            r_new_count  <= count_wide[7:0];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.alloc_addr   = r_alloc_addr;
    assign o_rsp.reached_zero = r_zero;
    assign o_rsp.new_count    = r_new_count;

    // A finished item always leaves a response behind.
    a_exec_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && n_state == ST_IDLE) |=> r_out_valid)
        else $error("completed item left no response");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !i_cnt_busy)
        else $error("item accepted during count clearing");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src_cmd.pop_stack |-> !i_src_stat.stack_empty)
        else $error("pop from empty page stack");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src_cmd.push |-> (!i_src_stat.stack_full && r_addr_ok))
        else $error("push onto full page stack or with bad address");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cnt_wr_en |-> (r_state == ST_EXEC && (r_addr_ok || r_action == ACT_ALLOC)))
        else $error("count write outside a valid execute cycle");

endmodule

### sv/refcounted_page_allocator.sv
// Reference-counted page allocator.
// Requests arrive on i_req (action and page address), one beat each; every
// request yields exactly one response beat on o_rsp (status, allocated address,
// reached-zero flag and the page's count after the action).
// Allocate pops the most recently returned page, or else the highest page not
// yet handed out; free, increment and decrement take a page-aligned address.
// Errors are reported in the status field and leave all state unchanged.
// Each request is accepted with address decode and the synchronous read of the
// count and page stack memories, then executed with the read-modify-write.
// The response is registered and appears the cycle after the execute cycle;
// a new request is accepted only once the previous one has left execute.
// If the receiver stalls, the finished response waits in the output register;
// the block accepts the next request and holds it in execute until it drains.
// After reset the count memory is cleared one entry per cycle, across all
// MAX_PAGES entries, during which no request is accepted. Base page and page
// count must be written over APB only while the block is idle; the block itself
// leaves this to the user. A page count write restarts the fresh page counter.
module refcounted_page_allocator import rpa_pkg::*; #(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rpa_req_if.sink           i_req,
    rpa_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(MAX_PAGES);

    logic [BASE_W-1:0]     base_page;
    logic [NUM_W-1:0]      pages_in_use;
    logic                  reload;
    logic [NUM_W-1:0]      reload_pages;
    logic                  cnt_rd_en;
    logic [IDX_W-1:0]      cnt_rd_idx;
    logic [COUNT_BITS-1:0] cnt_rd_data;
    logic                  cnt_wr_en;
    logic [IDX_W-1:0]      cnt_wr_idx;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic                  cnt_busy;
    t_src_cmd              src_cmd;
    t_src_stat             src_stat;
    logic [IDX_W-1:0]      push_idx;
    logic [IDX_W-1:0]      top_idx;
    logic [IDX_W-1:0]      fresh_idx;

    rpa_cfg_regs #(
        .MAX_PAGES (MAX_PAGES)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_base_page    (base_page),
        .o_pages_in_use (pages_in_use),
        .o_reload       (reload),
        .o_reload_pages (reload_pages)
    );

    rpa_ref_counts #(
        .MAX_PAGES  (MAX_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_counts (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (cnt_rd_en),
        .i_rd_idx  (cnt_rd_idx),
        .o_rd_data (cnt_rd_data),
        .i_wr_en   (cnt_wr_en),
        .i_wr_idx  (cnt_wr_idx),
        .i_wr_data (cnt_wr_data),
        .o_busy    (cnt_busy)
    );

    rpa_page_source #(
        .MAX_PAGES (MAX_PAGES)
    ) u_source (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (src_cmd),
        .i_push_idx     (push_idx),
        .i_reload       (reload),
        .i_reload_pages (reload_pages),
        .o_stat         (src_stat),
        .o_top_idx      (top_idx),
        .o_fresh_idx    (fresh_idx)
    );

    rpa_core #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .i_base_page    (base_page),
        .i_pages_in_use (pages_in_use),
        .i_cnt_busy     (cnt_busy),
        .o_cnt_rd_en    (cnt_rd_en),
        .o_cnt_rd_idx   (cnt_rd_idx),
        .i_cnt_rd_data  (cnt_rd_data),
        .o_cnt_wr_en    (cnt_wr_en),
        .o_cnt_wr_idx   (cnt_wr_idx),
        .o_cnt_wr_data  (cnt_wr_data),
        .o_src_cmd      (src_cmd),
        .o_push_idx     (push_idx),
        .i_src_stat     (src_stat),
        .i_top_idx      (top_idx),
        .i_fresh_idx    (fresh_idx)
    );

endmodule
